// File: src/baro_pressure_temp_compensation_defines.svh
// assertion macros used by the checker file of the compensation block
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpt check failed");

// next-cycle implication, disabled while reset is low
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpt check failed");

`endif

// File: src/bpt_pkg.sv
// constants, register codes and scale table of the pressure/temperature compensation block
`default_nettype none

package bpt_pkg;

    // fixed-point formats
    localparam int FRACTION_BITS = 24;
    localparam int RECIP_BITS    = 24;
    localparam int TEMP_OUT_FRAC = 8;
    localparam int PRES_OUT_FRAC = 6;

    // oversampling scale factors picked by the select registers
    localparam logic [23:0] SCALE_ROM [0:7] = '{
        24'd524288,  24'd1572864, 24'd3670016, 24'd7864320,
        24'd253952,  24'd516096,  24'd1040384, 24'd2088960
    };

    // configuration register indexes
    localparam logic [2:0] CFG_COEF_C0_C1           = 3'd0;
    localparam logic [2:0] CFG_COEF_C00_C10         = 3'd1;
    localparam logic [2:0] CFG_COEF_C01_C11_C20_C21 = 3'd2;
    localparam logic [2:0] CFG_COEF_C30             = 3'd3;
    localparam logic [2:0] CFG_PRES_SCALE_SEL       = 3'd4;
    localparam logic [2:0] CFG_TEMP_SCALE_SEL       = 3'd5;

    // reset values of the scale selects
    localparam logic [2:0] PRES_SEL_RESET = 3'd4;
    localparam logic [2:0] TEMP_SEL_RESET = 3'd3;

endpackage

`default_nettype wire

// File: src/baro_pressure_temp_compensation.sv
// top level of the barometric pressure and temperature compensation pipeline
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------------------------
//  in      | i_in_valid | o_in_ready  | i_raw_pressure, i_raw_temperature
//  out     | o_out_valid| i_out_ready | o_temperature_q8, o_pressure_q6, o_saturated
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one word enters per cycle while o_in_ready is high; the pipeline depth is set by
//  the nested pressure polynomial, whose fixed-point multiplies px*a1 and px*a2 run
//  behind one another in bpt_mulq instances, each three stages deep.
//  reset is synchronous, clears valid bits and loads the register reset values; no sweep.
//  a stalled output parks one word in a skid register; only then is o_in_ready low and
//  the whole pipeline holds.
`default_nettype none

module baro_pressure_temp_compensation #(
    parameter int FRACTION_BITS = bpt_pkg::FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_raw_pressure,
    input  logic signed [23:0] i_raw_temperature,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_temperature_q8,
    output logic signed [27:0] o_pressure_q6,
    output logic               o_saturated,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    // internal widths
    localparam int RW   = FRACTION_BITS + 7;          // reciprocal
    localparam int PW   = 24 + RW + 1;                // raw times reciprocal
    localparam int XW   = FRACTION_BITS + 7;          // scaled pressure/temperature
    localparam int A1W  = FRACTION_BITS + 23;         // c20 + px*c30
    localparam int BW   = FRACTION_BITS + 23;         // c11 + px*c21
    localparam int TCW  = FRACTION_BITS + 23;         // tx*c01
    localparam int A2W  = FRACTION_BITS + 30;         // c10 + px*a1
    localparam int TXW  = FRACTION_BITS + 13;         // tx*px
    localparam int TW   = FRACTION_BITS + 19;         // temperature before output shift
    localparam int TSH  = FRACTION_BITS - bpt_pkg::TEMP_OUT_FRAC;
    localparam int PSH  = FRACTION_BITS - bpt_pkg::PRES_OUT_FRAC;

    localparam logic signed [TW:0] TQ_MAX = (TW + 1)'(8388607);
    localparam logic signed [TW:0] TQ_MIN = (TW + 1)'(-8388608);
    localparam logic signed [64:0] PQ_MAX = 65'sd134217727;
    localparam logic signed [64:0] PQ_MIN = -65'sd134217728;

    typedef struct packed {
        logic signed [23:0] tq8;
        logic signed [27:0] pq6;
        logic               sat;
    } t_result;

    // 64-bit add clamped to the signed range
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    // configuration registers
    logic [23:0] r_coef_c0_c1;
    logic [39:0] r_coef_c00_c10;
    logic [63:0] r_coef_c01_c11_c20_c21;
    logic [15:0] r_coef_c30;
    logic [2:0]  r_pres_sel;
    logic [2:0]  r_temp_sel;

    logic        w_en;

    // reciprocal table and coefficient fields
    logic [RW-1:0]        w_recip [0:7];
    logic signed [RW:0]   w_recip_p;
    logic signed [RW:0]   w_recip_t;
    logic signed [11:0]   w_c0;
    logic signed [11:0]   w_c1;
    logic signed [19:0]   w_c00;
    logic signed [19:0]   w_c10;
    logic signed [15:0]   w_c01;
    logic signed [15:0]   w_c11;
    logic signed [15:0]   w_c20;
    logic signed [15:0]   w_c21;
    logic signed [15:0]   w_c30;
    logic signed [A1W-1:0] w_c20q;
    logic signed [BW-1:0]  w_c11q;
    logic signed [A2W-1:0] w_c10q;
    logic signed [63:0]    w_c00q;
    logic signed [TW-1:0]  w_c0q;

    // pipeline registers
    logic [14:1]            r_vld;
    logic signed [PW-1:0]   r1_pprod;
    logic signed [PW-1:0]   r1_tprod;
    logic signed [PW-1:0]   w_prnd;
    logic signed [PW-1:0]   w_trnd_s;
    logic signed [PW-1:0]   w_psh;
    logic signed [PW-1:0]   w_tsh_s;
    logic signed [XW-1:0]   r_px [2:8];
    logic signed [XW-1:0]   r2_tx;
    logic signed [A1W-1:0]  r3_pc30;
    logic signed [BW-1:0]   r3_pc21;
    logic signed [TW-1:0]   r3_c1tx;
    logic signed [TCW-1:0]  r_tc01 [3:12];
    logic signed [A1W-1:0]  r4_a1;
    logic signed [BW-1:0]   r_b [4:10];
    logic signed [TW-1:0]   r4_t;
    logic signed [TW:0]     w_trnd;
    logic signed [TW:0]     w_tsh;
    logic signed [23:0]     r_tq8 [5:14];
    logic                   r_tsat [5:14];
    logic signed [TXW-1:0]  r_txpx [6:10];
    logic signed [A2W-1:0]  r8_a2;
    logic signed [63:0]     r12_p1;
    logic signed [63:0]     r13_p2;
    logic signed [63:0]     r14_p3;
    logic signed [63:0]     w_m6;
    logic signed [63:0]     w_m2;
    logic signed [63:0]     w_m4;
    logic signed [63:0]     w_m7;
    logic signed [23:0]     w_tq8_clamp;
    logic                   w_tsat;

    // final stage and output registers
    logic signed [64:0] w_prs;
    logic signed [64:0] w_prs_sh;
    t_result            w_fin;
    t_result            r_out;
    t_result            r_skid;
    logic               r_out_vld;
    logic               r_skid_vld;
    logic               n_out_vld;
    logic               n_skid_vld;
    logic               w_load_out;
    logic               w_load_skid;
    logic               w_out_from_skid;

    // the pipeline moves whenever the skid register is free
    assign w_en        = ~r_skid_vld;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // configuration write decoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_c0_c1           <= '0;
            r_coef_c00_c10         <= '0;
            r_coef_c01_c11_c20_c21 <= '0;
            r_coef_c30             <= '0;
            r_pres_sel             <= bpt_pkg::PRES_SEL_RESET;
            r_temp_sel             <= bpt_pkg::TEMP_SEL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpt_pkg::CFG_COEF_C0_C1:           r_coef_c0_c1 <= i_cfg_data[23:0];
                bpt_pkg::CFG_COEF_C00_C10:         r_coef_c00_c10 <= i_cfg_data[39:0];
                bpt_pkg::CFG_COEF_C01_C11_C20_C21: r_coef_c01_c11_c20_c21 <= i_cfg_data;
                bpt_pkg::CFG_COEF_C30:             r_coef_c30 <= i_cfg_data[15:0];
                bpt_pkg::CFG_PRES_SCALE_SEL:       r_pres_sel <= i_cfg_data[2:0];
                bpt_pkg::CFG_TEMP_SCALE_SEL:       r_temp_sel <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // rounded reciprocals of the scale factors, worked out at elaboration
    for (genvar g = 0; g < 8; g++) begin : g_recip
        localparam logic [63:0] Scale = 64'(bpt_pkg::SCALE_ROM[g]);
        localparam logic [63:0] Recip =
            ((64'd1 << (FRACTION_BITS + bpt_pkg::RECIP_BITS)) + Scale / 2) / Scale;
        assign w_recip[g] = Recip[RW-1:0];
    end

    assign w_recip_p = {1'b0, w_recip[r_pres_sel]};
    assign w_recip_t = {1'b0, w_recip[r_temp_sel]};

    // coefficient fields and their fixed-point forms
    assign w_c0  = r_coef_c0_c1[23:12];
    assign w_c1  = r_coef_c0_c1[11:0];
    assign w_c00 = r_coef_c00_c10[39:20];
    assign w_c10 = r_coef_c00_c10[19:0];
    assign w_c01 = r_coef_c01_c11_c20_c21[63:48];
    assign w_c11 = r_coef_c01_c11_c20_c21[47:32];
    assign w_c20 = r_coef_c01_c11_c20_c21[31:16];
    assign w_c21 = r_coef_c01_c11_c20_c21[15:0];
    assign w_c30 = r_coef_c30;

    assign w_c20q = {{(A1W - 16 - FRACTION_BITS){w_c20[15]}}, w_c20, {FRACTION_BITS{1'b0}}};
    assign w_c11q = {{(BW - 16 - FRACTION_BITS){w_c11[15]}}, w_c11, {FRACTION_BITS{1'b0}}};
    assign w_c10q = {{(A2W - 20 - FRACTION_BITS){w_c10[19]}}, w_c10, {FRACTION_BITS{1'b0}}};
    assign w_c00q = {{(64 - 20 - FRACTION_BITS){w_c00[19]}}, w_c00, {FRACTION_BITS{1'b0}}};
    assign w_c0q  = {{(TW - 12 - (FRACTION_BITS - 1)){w_c0[11]}}, w_c0,
                     {(FRACTION_BITS - 1){1'b0}}};

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[13:1], i_in_valid};
        end
    end

    // stage 1: raw reading times reciprocal
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pprod <= i_raw_pressure * w_recip_p;
            r1_tprod <= i_raw_temperature * w_recip_t;
        end
    end

    // stage 2: drop the reciprocal fraction, rounding half away from zero
    assign w_prnd   = r1_pprod + PW'(64'd1 << (bpt_pkg::RECIP_BITS - 1))
                    - {{(PW - 1){1'b0}}, r1_pprod[PW-1]};
    assign w_trnd_s = r1_tprod + PW'(64'd1 << (bpt_pkg::RECIP_BITS - 1))
                    - {{(PW - 1){1'b0}}, r1_tprod[PW-1]};
    assign w_psh    = w_prnd >>> bpt_pkg::RECIP_BITS;
    assign w_tsh_s  = w_trnd_s >>> bpt_pkg::RECIP_BITS;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px[2] <= w_psh[XW-1:0];
            r2_tx   <= w_tsh_s[XW-1:0];
        end
    end

    // stage 3: products with exact coefficients; tx*px starts in its multiplier
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pc30   <= r_px[2] * w_c30;
            r3_pc21   <= r_px[2] * w_c21;
            r3_c1tx   <= r2_tx * w_c1;
            r_tc01[3] <= r2_tx * w_c01;
        end
    end

    bpt_mulq #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul_txpx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{(64 - XW){r2_tx[XW-1]}}, r2_tx}),
        .i_b   ({{(64 - XW){r_px[2][XW-1]}}, r_px[2]}),
        .o_p   (w_m6)
    );

    // stage 4: inner sums of the polynomial and the temperature sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_a1  <= w_c20q + r3_pc30;
            r_b[4] <= w_c11q + r3_pc21;
            r4_t   <= w_c0q + r3_c1tx;
        end
    end

    // stage 5: temperature to 1/256 degree with clamp; px*a1 starts
    assign w_trnd = {r4_t[TW-1], r4_t} + (TW + 1)'(64'd1 << (TSH - 1))
                  - {{TW{1'b0}}, r4_t[TW-1]};
    assign w_tsh  = w_trnd >>> TSH;

    always_comb begin
        w_tsat = 1'b0;
        if (w_tsh > TQ_MAX) begin
            w_tq8_clamp = TQ_MAX[23:0];
            w_tsat      = 1'b1;
        end else if (w_tsh < TQ_MIN) begin
            w_tq8_clamp = TQ_MIN[23:0];
            w_tsat      = 1'b1;
        end else begin
            w_tq8_clamp = w_tsh[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tq8[5]  <= w_tq8_clamp;
            r_tsat[5] <= w_tsat;
            r_txpx[6] <= w_m6[TXW-1:0];
        end
    end

    bpt_mulq #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul_pa1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{(64 - XW){r_px[4][XW-1]}}, r_px[4]}),
        .i_b   ({{(64 - A1W){r4_a1[A1W-1]}}, r4_a1}),
        .o_p   (w_m2)
    );

    // delay lines that carry operands to their later stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 3; k <= 8; k++) begin
                r_px[k] <= r_px[k-1];
            end
            for (int k = 4; k <= 12; k++) begin
                r_tc01[k] <= r_tc01[k-1];
            end
            for (int k = 5; k <= 10; k++) begin
                r_b[k] <= r_b[k-1];
            end
            for (int k = 7; k <= 10; k++) begin
                r_txpx[k] <= r_txpx[k-1];
            end
            for (int k = 6; k <= 14; k++) begin
                r_tq8[k]  <= r_tq8[k-1];
                r_tsat[k] <= r_tsat[k-1];
            end
        end
    end

    // stage 8: c10 + px*a1
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_a2 <= w_c10q + w_m2[A2W-1:0];
        end
    end

    // stages 9 to 11: px*a2
    bpt_mulq #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul_pa2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{(64 - XW){r_px[8][XW-1]}}, r_px[8]}),
        .i_b   ({{(64 - A2W){r8_a2[A2W-1]}}, r8_a2}),
        .o_p   (w_m4)
    );

    // stages 11 to 13: (tx*px) * (c11 + px*c21)
    bpt_mulq #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul_txpxb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   ({{(64 - TXW){r_txpx[10][TXW-1]}}, r_txpx[10]}),
        .i_b   ({{(64 - BW){r_b[10][BW-1]}}, r_b[10]}),
        .o_p   (w_m7)
    );

    // stages 12 to 14: saturating accumulation of the pressure terms
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_p1 <= sat_add64(w_c00q, w_m4);
            r13_p2 <= sat_add64(r12_p1, {{(64 - TCW){r_tc01[12][TCW-1]}}, r_tc01[12]});
            r14_p3 <= sat_add64(r13_p2, w_m7);
        end
    end

    // final stage: pressure to 1/64 Pa with clamp
    assign w_prs    = {r14_p3[63], r14_p3} + 65'(64'd1 << (PSH - 1))
                    - {64'd0, r14_p3[63]};
    assign w_prs_sh = w_prs >>> PSH;

    always_comb begin
        w_fin.tq8 = r_tq8[14];
        w_fin.sat = r_tsat[14];
        if (w_prs_sh > PQ_MAX) begin
            w_fin.pq6 = PQ_MAX[27:0];
            w_fin.sat = 1'b1;
        end else if (w_prs_sh < PQ_MIN) begin
            w_fin.pq6 = PQ_MIN[27:0];
            w_fin.sat = 1'b1;
        end else begin
            w_fin.pq6 = w_prs_sh[27:0];
        end
    end

    // output register with skid
    always_comb begin
        n_out_vld       = r_out_vld;
        n_skid_vld      = r_skid_vld;
        w_load_out      = 1'b0;
        w_load_skid     = 1'b0;
        w_out_from_skid = 1'b0;
        if (r_skid_vld) begin
            if (i_out_ready) begin
                n_out_vld       = 1'b1;
                n_skid_vld      = 1'b0;
                w_out_from_skid = 1'b1;
            end
        end else if (!r_out_vld || i_out_ready) begin
            n_out_vld  = r_vld[14];
            w_load_out = 1'b1;
        end else if (r_vld[14]) begin
            n_skid_vld  = 1'b1;
            w_load_skid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= w_fin;
        end
        if (w_load_skid) begin
            r_skid <= w_fin;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_temperature_q8 = r_out.tq8;
    assign o_pressure_q6    = r_out.pq6;
    assign o_saturated      = r_out.sat;

endmodule

`default_nettype wire

// File: src/bpt_mulq.sv
// pipelined fixed-point multiply: round(a*b / 2^fraction), clamped to +/-(2^63-1)
`default_nettype none

module bpt_mulq #(
    parameter int FRACTION_BITS = bpt_pkg::FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    localparam logic signed [127:0] QMAX = {65'd0, {63{1'b1}}};
    localparam logic signed [127:0] QMIN = {{65{1'b1}}, {62{1'b0}}, 1'b1};

    logic signed [32:0]  w_a_lo;
    logic signed [31:0]  w_a_hi;
    logic signed [32:0]  w_b_lo;
    logic signed [31:0]  w_b_hi;
    logic signed [65:0]  r_ll;
    logic signed [64:0]  r_lh;
    logic signed [64:0]  r_hl;
    logic signed [63:0]  r_hh;
    logic signed [127:0] r_prod;
    logic signed [127:0] w_rnd;
    logic signed [127:0] w_q;
    logic signed [63:0]  w_clamp;

    // split both operands into an unsigned low half and a signed high half
    assign w_a_lo = {1'b0, i_a[31:0]};
    assign w_a_hi = i_a[63:32];
    assign w_b_lo = {1'b0, i_b[31:0]};
    assign w_b_hi = i_b[63:32];

    // stage a: four partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= w_a_lo * w_b_lo;
            r_lh <= w_a_lo * w_b_hi;
            r_hl <= w_a_hi * w_b_lo;
            r_hh <= w_a_hi * w_b_hi;
        end
    end

    // stage b: full 128-bit product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{62{r_ll[65]}}, r_ll}
                    + {{31{r_lh[64]}}, r_lh, 32'd0}
                    + {{31{r_hl[64]}}, r_hl, 32'd0}
                    + {r_hh, 64'd0};
        end
    end

    // stage c: round half away from zero, then clamp the magnitude
    assign w_rnd = r_prod + (128'd1 << (FRACTION_BITS - 1)) - {127'd0, r_prod[127]};
    assign w_q   = w_rnd >>> FRACTION_BITS;

    always_comb begin
        if (w_q > QMAX) begin
            w_clamp = QMAX[63:0];
        end else if (w_q < QMIN) begin
            w_clamp = QMIN[63:0];
        end else begin
            w_clamp = w_q[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= w_clamp;
        end
    end

endmodule

`default_nettype wire

// File: src/bpt_checker.sv
// port-level checks of the compensation block and their bind
`default_nettype none

`include "baro_pressure_temp_compensation_defines.svh"

module bpt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [23:0] o_temperature_q8,
    input wire logic signed [27:0] o_pressure_q6,
    input wire logic               o_saturated
);

    // a waiting result word stays offered
    `BPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a waiting result word keeps its payload
    `BPT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_temperature_q8) && $stable(o_pressure_q6) && $stable(o_saturated))

    // the flag is only raised with a field sitting at a range limit
    `BPT_ASSERT_IMP(a_sat_at_limit, i_clk, i_rst_n, o_out_valid && o_saturated, o_temperature_q8 == 24'sh7FFFFF || o_temperature_q8 == -24'sh800000 || o_pressure_q6 == 28'sh7FFFFFF || o_pressure_q6 == -28'sh8000000)

    // input back-pressure only follows a stalled result word
    `BPT_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && $past(o_out_valid && !i_out_ready))

endmodule

bind baro_pressure_temp_compensation bpt_checker u_bpt_checker (.*);

`default_nettype wire

// File: dv/bpt_compensation_check.sv
// result checker for the compensation block: tracks register writes, predicts and compares words
`timescale 1ns / 100ps

module bpt_compensation_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [23:0] i_raw_pressure,
    input  logic signed [23:0] i_raw_temperature,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [23:0] i_temperature_q8,
    input  logic signed [27:0] i_pressure_q6,
    input  logic               i_saturated,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_outstanding,
    output int                 o_error_count
);
    import bpt_pkg::*;

    localparam int     FB    = FRACTION_BITS;
    localparam longint Q_ONE = longint'(1) << FRACTION_BITS;

    typedef struct packed {
        logic signed [23:0] temperature_q8;
        logic signed [27:0] pressure_q6;
        logic               saturated;
    } comp_word_t;

    // copy of the register file as seen on the write channel
    logic [23:0] cf_c0_c1;
    logic [39:0] cf_c00_c10;
    logic [63:0] cf_c01_c11_c20_c21;
    logic [15:0] cf_c30;
    logic [2:0]  cf_pres_sel;
    logic [2:0]  cf_temp_sel;

    comp_word_t predicted_words[$];
    int         mismatches;

    // signed sum clipped to the 64-bit range
    function automatic longint sat_sum(input longint a, input longint b);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return r;
    endfunction

    // fixed-point product, rounded half away from zero, magnitude clipped
    function automatic longint fx_mul(input longint a, input longint b);
        logic [63:0]  ua, ub;
        logic [127:0] q;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        q   = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (FB - 1))) >> FB;
        if (q > 128'h7FFF_FFFF_FFFF_FFFF)
            q = 128'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // raw reading divided by its oversampling factor via the rounded reciprocal
    function automatic longint scale_reading(input logic signed [23:0] raw, input logic [2:0] sel);
        logic [63:0] k, recip, ur, m;
        k     = 64'(SCALE_ROM[sel]);
        recip = ((64'd1 << (FRACTION_BITS + RECIP_BITS)) + k / 2) / k;
        ur    = (raw < 0) ? 64'(-longint'(raw)) : 64'(longint'(raw));
        m     = (ur * recip + (64'd1 << (RECIP_BITS - 1))) >> RECIP_BITS;
        return (raw < 0) ? -longint'(m) : longint'(m);
    endfunction

    // signed shift right, rounded half away from zero
    function automatic longint round_away(input longint v, input int s);
        logic [63:0] m;
        m = (((v < 0) ? 64'(-v) : 64'(v)) + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // clip to a signed field of w bits
    function automatic longint clip(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // compensated temperature and pressure for one raw pair under the current registers
    function automatic comp_word_t compensate(input logic signed [23:0] raw_p,
                                              input logic signed [23:0] raw_t);
        longint     c0, c1, c00, c10, c01, c11, c20, c21, c30;
        longint     px, tx, t, p, a, b, tc, pc;
        comp_word_t w;
        c0  = longint'($signed(cf_c0_c1[23:12]));
        c1  = longint'($signed(cf_c0_c1[11:0]));
        c00 = longint'($signed(cf_c00_c10[39:20])) * Q_ONE;
        c10 = longint'($signed(cf_c00_c10[19:0])) * Q_ONE;
        c01 = longint'($signed(cf_c01_c11_c20_c21[63:48])) * Q_ONE;
        c11 = longint'($signed(cf_c01_c11_c20_c21[47:32])) * Q_ONE;
        c20 = longint'($signed(cf_c01_c11_c20_c21[31:16])) * Q_ONE;
        c21 = longint'($signed(cf_c01_c11_c20_c21[15:0])) * Q_ONE;
        c30 = longint'($signed(cf_c30)) * Q_ONE;
        px  = scale_reading(raw_p, cf_pres_sel);
        tx  = scale_reading(raw_t, cf_temp_sel);

        // half of c0 is exact in this format
        t = c0 * (Q_ONE >>> 1) + c1 * tx;

        // nested polynomial, evaluated innermost first
        a = sat_sum(c20, fx_mul(px, c30));
        a = sat_sum(c10, fx_mul(px, a));
        b = sat_sum(c11, fx_mul(px, c21));
        p = sat_sum(c00, fx_mul(px, a));
        p = sat_sum(p, fx_mul(tx, c01));
        p = sat_sum(p, fx_mul(fx_mul(tx, px), b));

        t  = round_away(t, FB - TEMP_OUT_FRAC);
        p  = round_away(p, FB - PRES_OUT_FRAC);
        tc = clip(t, 24);
        pc = clip(p, 28);
        w.temperature_q8 = tc[23:0];
        w.pressure_q6    = pc[27:0];
        w.saturated      = (tc != t) || (pc != p);
        return w;
    endfunction

    // follow the three channels
    always @(posedge i_clk) begin : track
        comp_word_t want;
        if (!i_rst_n) begin
            cf_c0_c1           = '0;
            cf_c00_c10         = '0;
            cf_c01_c11_c20_c21 = '0;
            cf_c30             = '0;
            cf_pres_sel        = PRES_SEL_RESET;
            cf_temp_sel        = TEMP_SEL_RESET;
            predicted_words.delete();
            mismatches         = 0;
            o_outstanding     <= 0;
            o_error_count     <= 0;
        end else begin
            // register writes; unknown indexes leave everything alone
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COEF_C0_C1:           cf_c0_c1           = i_cfg_data[23:0];
                    CFG_COEF_C00_C10:         cf_c00_c10         = i_cfg_data[39:0];
                    CFG_COEF_C01_C11_C20_C21: cf_c01_c11_c20_c21 = i_cfg_data;
                    CFG_COEF_C30:             cf_c30             = i_cfg_data[15:0];
                    CFG_PRES_SCALE_SEL:       cf_pres_sel        = i_cfg_data[2:0];
                    CFG_TEMP_SCALE_SEL:       cf_temp_sel        = i_cfg_data[2:0];
                    default: ;
                endcase
            end

            // accepted raw pair
            if (i_in_valid && i_in_ready)
                predicted_words.push_back(compensate(i_raw_pressure, i_raw_temperature));

            // accepted result word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("result word arrived with nothing predicted");
                    mismatches++;
                end else begin
                    want = predicted_words.pop_front();
                    if (i_temperature_q8 !== want.temperature_q8) begin
                        $error("temperature_q8: expected %0d, actual %0d",
                               want.temperature_q8, i_temperature_q8);
                        mismatches++;
                    end
                    if (i_pressure_q6 !== want.pressure_q6) begin
                        $error("pressure_q6: expected %0d, actual %0d",
                               want.pressure_q6, i_pressure_q6);
                        mismatches++;
                    end
                    if (i_saturated !== want.saturated) begin
                        $error("saturated: expected %0d, actual %0d",
                               want.saturated, i_saturated);
                        mismatches++;
                    end
                end
            end

            o_outstanding <= predicted_words.size();
            o_error_count <= mismatches;
        end
    end

endmodule

// File: dv/tb_baro_pressure_temp_compensation.sv
// stimulus and verdict for the pressure/temperature compensation block
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensation;
    import bpt_pkg::*;

    localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [2:0] CFG_UNUSED_7 = 3'd7;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 200;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_WORDS   = 110;
    localparam int SETTLE_CYCLES = 20;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic signed [23:0] raw_pressure = '0;
    logic signed [23:0] raw_temperature = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               hold_arm = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [23:0] o_temperature_q8;
    logic signed [27:0] o_pressure_q6;
    logic               o_saturated;
    logic               o_cfg_ready;

    int outstanding;
    int error_count;
    int send_idle_pct = 20;
    int recv_idle_pct = 71;
    int cycle_count = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    baro_pressure_temp_compensation u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_raw_pressure    (raw_pressure),
        .i_raw_temperature (raw_temperature),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_temperature_q8  (o_temperature_q8),
        .o_pressure_q6     (o_pressure_q6),
        .o_saturated       (o_saturated),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    bpt_compensation_check u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (o_in_ready),
        .i_raw_pressure    (raw_pressure),
        .i_raw_temperature (raw_temperature),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .i_temperature_q8  (o_temperature_q8),
        .i_pressure_q6     (o_pressure_q6),
        .i_saturated       (o_saturated),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_outstanding     (outstanding),
        .o_error_count     (error_count)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_baro_pressure_temp_compensation: done, errors");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one raw pair, with random gaps, and wait for it to be taken
    task automatic send_sample(input logic [23:0] p, input logic [23:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid        <= 1'b1;
        raw_pressure    <= p;
        raw_temperature <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drop valid and wait for every predicted word to come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // one register write, valid left high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // full register set; an unused index with junk goes first, high bits carry junk too
    task automatic program_settings(input logic [23:0] c0_c1, input logic [39:0] c00_c10,
                                    input logic [63:0] c01_c11_c20_c21, input logic [15:0] c30,
                                    input logic [2:0] pres_sel, input logic [2:0] temp_sel);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg($urandom_range(1) ? CFG_UNUSED_6 : CFG_UNUSED_7, junk);
        write_reg(CFG_COEF_C0_C1, {junk[63:24], c0_c1});
        write_reg(CFG_COEF_C00_C10, {junk[23:0], c00_c10});
        write_reg(CFG_COEF_C01_C11_C20_C21, c01_c11_c20_c21);
        write_reg(CFG_COEF_C30, {junk[47:0], c30});
        write_reg(CFG_PRES_SCALE_SEL, {junk[63:3], pres_sel});
        write_reg(CFG_TEMP_SCALE_SEL, {junk[60:0], temp_sel});
        cfg_valid <= 1'b0;
    endtask

    // coefficient of w bits: extremes, small values or anything
    function automatic logic [63:0] rand_coef(input int w);
        logic [63:0] mask;
        logic [63:0] v;
        mask = (64'd1 << w) - 1;
        case ($urandom_range(3))
            0: v = mask >> 1;
            1: v = 64'd1 << (w - 1);
            2: v = 64'(longint'($urandom_range(255)) - 128) & mask;
            default: v = {$urandom, $urandom} & mask;
        endcase
        return v;
    endfunction

    task automatic program_random_settings();
        logic [23:0] c0_c1;
        logic [39:0] c00_c10;
        logic [63:0] c4;
        logic [15:0] c30;
        c0_c1   = {rand_coef(12)[11:0], rand_coef(12)[11:0]};
        c00_c10 = {rand_coef(20)[19:0], rand_coef(20)[19:0]};
        c4      = {rand_coef(16)[15:0], rand_coef(16)[15:0],
                   rand_coef(16)[15:0], rand_coef(16)[15:0]};
        c30     = rand_coef(16)[15:0];
        program_settings(c0_c1, c00_c10, c4, c30,
                         3'($urandom_range(7)), 3'($urandom_range(7)));
    endtask

    // raw reading: corners, small magnitudes or the full range
    function automatic logic [23:0] rand_reading();
        logic [23:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    2: v = 24'h000000;
                    default: v = 24'hFFFFFF;
                endcase
            end
            1, 2: v = 24'(int'($urandom_range(131071)) - 65536);
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    // corner pairs sent under each directed setting
    task automatic send_corners();
        send_sample(24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000);
        send_sample(24'h7FFFFF, 24'h800000);
        send_sample(24'h800000, 24'h7FFFFF);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'h000001, 24'hFFFFFF);
        send_sample(24'hFFFFFF, 24'h000001);
        send_sample(-24'sd250000, 24'sd500000);
        wait_drained();
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sensor-like coefficients, middle selects
        program_settings({12'sd200, -12'sd260}, {20'sd80000, -20'sd50000},
                         {-16'sd3000, 16'sd1200, -16'sd8000, 16'sd150}, -16'sd1500,
                         3'd3, 3'd3);
        send_corners();

        // largest positive coefficients, select extremes
        program_settings(24'h7FF7FF, 40'h7FFFF_7FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF,
                         3'd0, 3'd7);
        send_corners();

        // most negative coefficients, the other select extremes
        program_settings(24'h800800, 40'h80000_80000, 64'h8000_8000_8000_8000, 16'h8000,
                         3'd7, 3'd0);
        send_corners();

        // random settings and words through the three idling modes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 20;
            end else if (ph == 2 * RAND_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_random_settings();
            // long result stall while words keep coming, fills the pipeline
            if (ph == 2 * RAND_PHASES / 3)
                hold_arm <= 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_sample(rand_reading(), rand_reading());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_baro_pressure_temp_compensation: done, clean");
        else
            $display("tb_baro_pressure_temp_compensation: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bpt_pkg.sv
src/bpt_mulq.sv
src/baro_pressure_temp_compensation.sv
src/bpt_checker.sv
dv/bpt_compensation_check.sv
dv/tb_baro_pressure_temp_compensation.sv
